// File: hw/rtl/sdz_pkg.sv
// ----------------------------------------------------------------------------
// sdz_pkg
// Shared types and constants of the radial deadzone block.
// ----------------------------------------------------------------------------
package sdz_pkg;

  localparam int unsigned ISQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS   = 16;
  // squares, sum, root steps, divider set-up, divider steps, final
  localparam int unsigned LAT = 2 + ISQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [14:0] MAG_CLAMP = 15'h7FFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR  = 2'd2;

  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [7:0]  TRIG_THR_RST = 8'd30;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_pull;
    logic [7:0]         right_pull;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_dir_x;
    logic signed [15:0] left_dir_y;
    logic [14:0]        left_excess;
    logic [15:0]        left_level;
    logic signed [15:0] right_dir_x;
    logic signed [15:0] right_dir_y;
    logic [14:0]        right_excess;
    logic [15:0]        right_level;
    logic [7:0]         left_pull_level;
    logic [7:0]         right_pull_level;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [14:0]        excess;
    logic [15:0]        level;
  } stick_res_t;

endpackage

// File: hw/rtl/sdz_stick.sv
// ----------------------------------------------------------------------------
// sdz_stick
// Pipelined magnitude, direction and deadzone scaling of one thumbstick.
// ----------------------------------------------------------------------------
module sdz_stick (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  x,
  input  logic signed [15:0]  y,
  input  logic [14:0]         dz,
  output sdz_pkg::stick_res_t res
);

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic        sx;
    logic        sy;
  } axes_t;

  localparam int unsigned NQ = sdz_pkg::ISQRT_STEPS;
  localparam int unsigned ND = sdz_pkg::DIV_STEPS;

  // squares
  axes_t       axes_r [0:NQ+1];
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;
  logic [31:0] n_r;

  // root steps
  logic [31:0] qn_r   [0:NQ-1];
  logic [18:0] qrem_r [0:NQ-1];
  logic [15:0] root_r [0:NQ-1];

  // divider stages
  logic [15:0] m_r    [0:ND];
  logic [15:0] remx_r [0:ND];
  logic [15:0] remy_r [0:ND];
  logic [15:0] qx_r   [0:ND];
  logic [15:0] qy_r   [0:ND];
  logic        sx_r   [0:ND];
  logic        sy_r   [0:ND];
  logic [14:0] dv_r   [0:ND];
  logic [14:0] reml_r [0:ND];
  logic [16:0] ql_r   [0:ND];
  logic [14:0] exc_r  [0:ND];

  sdz_pkg::stick_res_t res_r;

  axes_t a_nxt;

  always_comb begin
    a_nxt.sx = x[15];
    a_nxt.sy = y[15];
    a_nxt.ax = x[15] ? 16'(-x) : 16'(x);
    a_nxt.ay = y[15] ? 16'(-y) : 16'(y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axes_r[0] <= a_nxt;
      sqx_r     <= a_nxt.ax * a_nxt.ax;
      sqy_r     <= a_nxt.ay * a_nxt.ay;
      axes_r[1] <= axes_r[0];
      n_r       <= sqx_r + sqy_r;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NQ; k++) begin : g_root
      logic [31:0] n_in;
      logic [18:0] rem_in;
      logic [15:0] root_in;
      logic [18:0] rem_t;
      logic [18:0] trial;
      if (k == 0) begin : g_first
        assign n_in    = n_r;
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign n_in    = qn_r[k-1];
        assign rem_in  = qrem_r[k-1];
        assign root_in = root_r[k-1];
      end
      assign rem_t = {rem_in[16:0], n_in[31:30]};
      assign trial = {1'b0, root_in, 2'b01};
      always_ff @(posedge clk) begin
        if (en) begin
          qn_r[k]       <= {n_in[29:0], 2'b00};
          axes_r[k + 2] <= axes_r[k + 1];
          if (rem_t >= trial) begin
            qrem_r[k] <= rem_t - trial;
            root_r[k] <= {root_in[14:0], 1'b1};
          end else begin
            qrem_r[k] <= rem_t;
            root_r[k] <= {root_in[14:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // divider set-up
  logic [15:0] mag;
  logic [15:0] m_nxt;
  logic        outside;
  logic [14:0] clamp;
  logic [14:0] exc_nxt;
  logic [14:0] dv_nxt;
  axes_t       ae;

  always_comb begin
    ae      = axes_r[NQ+1];
    mag     = root_r[NQ-1];
    m_nxt   = (mag == '0) ? 16'd1 : mag;
    outside = (mag > {1'b0, dz}) && (dz != sdz_pkg::MAG_CLAMP);
    clamp   = mag[15] ? sdz_pkg::MAG_CLAMP : mag[14:0];
    exc_nxt = outside ? 15'(clamp - dz) : '0;
    dv_nxt  = outside ? 15'(sdz_pkg::MAG_CLAMP - dz) : 15'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m_nxt;
      sx_r[0]   <= ae.sx;
      sy_r[0]   <= ae.sy;
      exc_r[0]  <= exc_nxt;
      dv_r[0]   <= dv_nxt;
      qx_r[0]   <= {15'd0, ae.ax >= m_nxt};
      qy_r[0]   <= {15'd0, ae.ay >= m_nxt};
      remx_r[0] <= (ae.ax >= m_nxt) ? 16'(ae.ax - m_nxt) : ae.ax;
      remy_r[0] <= (ae.ay >= m_nxt) ? 16'(ae.ay - m_nxt) : ae.ay;
      ql_r[0]   <= {16'd0, exc_nxt >= dv_nxt};
      reml_r[0] <= (exc_nxt >= dv_nxt) ? 15'(exc_nxt - dv_nxt) : exc_nxt;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= ND; j++) begin : g_div
      logic [16:0] rx2;
      logic [16:0] ry2;
      logic [15:0] rl2;
      logic        bx;
      logic        by;
      logic        bl;
      assign rx2 = {remx_r[j-1], 1'b0};
      assign ry2 = {remy_r[j-1], 1'b0};
      assign rl2 = {reml_r[j-1], 1'b0};
      assign bx  = rx2 >= {1'b0, m_r[j-1]};
      assign by  = ry2 >= {1'b0, m_r[j-1]};
      assign bl  = rl2 >= {1'b0, dv_r[j-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[j]    <= m_r[j-1];
          sx_r[j]   <= sx_r[j-1];
          sy_r[j]   <= sy_r[j-1];
          exc_r[j]  <= exc_r[j-1];
          dv_r[j]   <= dv_r[j-1];
          ql_r[j]   <= {ql_r[j-1][15:0], bl};
          reml_r[j] <= bl ? 15'(rl2 - {1'b0, dv_r[j-1]}) : rl2[14:0];
        end
      end
      if (j < ND) begin : g_dir
        always_ff @(posedge clk) begin
          if (en) begin
            qx_r[j]   <= {qx_r[j-1][14:0], bx};
            qy_r[j]   <= {qy_r[j-1][14:0], by};
            remx_r[j] <= bx ? 16'(rx2 - {1'b0, m_r[j-1]}) : rx2[15:0];
            remy_r[j] <= by ? 16'(ry2 - {1'b0, m_r[j-1]}) : ry2[15:0];
          end
        end
      end else begin : g_hold
        always_ff @(posedge clk) begin
          if (en) begin
            qx_r[j]   <= qx_r[j-1];
            qy_r[j]   <= qy_r[j-1];
            remx_r[j] <= remx_r[j-1];
            remy_r[j] <= remy_r[j-1];
          end
        end
      end
    end
  endgenerate

  // saturate and apply sign
  sdz_pkg::stick_res_t res_nxt;

  always_comb begin
    if (sx_r[ND]) begin
      res_nxt.dir_x = 16'(16'd0 - qx_r[ND]);
    end else begin
      res_nxt.dir_x = qx_r[ND][15] ? 16'sh7FFF : qx_r[ND];
    end
    if (sy_r[ND]) begin
      res_nxt.dir_y = 16'(16'd0 - qy_r[ND]);
    end else begin
      res_nxt.dir_y = qy_r[ND][15] ? 16'sh7FFF : qy_r[ND];
    end
    res_nxt.excess = exc_r[ND];
    res_nxt.level  = ql_r[ND][16] ? 16'hFFFF : ql_r[ND][15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: hw/rtl/stick_radial_deadzone.sv
// An accepted item passes the squares, sum, root, divider set-up, divider and final registers.
// Throughput: one item per cycle while the output is not stalled; the root stages yield one bit each.
// A stalled output with a valid item holds the whole pipeline, input stall follows it.
// Reset clears the valid bits and loads the deadzone and trigger defaults.
// ----------------------------------------------------------------------------
// stick_radial_deadzone
// Radial deadzone and trigger threshold processing of one game pad sample.
// ----------------------------------------------------------------------------
module stick_radial_deadzone (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdz_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdz_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [sdz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdz_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned LAT = sdz_pkg::LAT;

  logic [14:0] left_dz_r;
  logic [14:0] right_dz_r;
  logic [7:0]  trig_thr_r;

  logic        vld_r   [0:LAT-1];
  logic [7:0]  ltrig_r [0:LAT-1];
  logic [7:0]  rtrig_r [0:LAT-1];
  logic        en;

  sdz_pkg::stick_res_t lres;
  sdz_pkg::stick_res_t rres;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r  <= sdz_pkg::LEFT_DZ_RST;
      right_dz_r <= sdz_pkg::RIGHT_DZ_RST;
      trig_thr_r <= sdz_pkg::TRIG_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdz_pkg::CFG_LEFT_DZ:  left_dz_r  <= cfg_wdata;
        sdz_pkg::CFG_RIGHT_DZ: right_dz_r <= cfg_wdata;
        sdz_pkg::CFG_TRIG_THR: trig_thr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ltrig_r[0] <= (in_item.left_pull > trig_thr_r) ? in_item.left_pull : 8'd0;
      rtrig_r[0] <= (in_item.right_pull > trig_thr_r) ? in_item.right_pull : 8'd0;
      for (int i = 1; i < LAT; i++) begin
        ltrig_r[i] <= ltrig_r[i-1];
        rtrig_r[i] <= rtrig_r[i-1];
      end
    end
  end

  sdz_stick u_left (
    .clk (clk),
    .en  (en),
    .x   (in_item.left_x),
    .y   (in_item.left_y),
    .dz  (left_dz_r),
    .res (lres)
  );

  sdz_stick u_right (
    .clk (clk),
    .en  (en),
    .x   (in_item.right_x),
    .y   (in_item.right_y),
    .dz  (right_dz_r),
    .res (rres)
  );

  assign out_valid = vld_r[LAT-1];

  always_comb begin
    out_item.left_dir_x       = lres.dir_x;
    out_item.left_dir_y       = lres.dir_y;
    out_item.left_excess      = lres.excess;
    out_item.left_level       = lres.level;
    out_item.right_dir_x      = rres.dir_x;
    out_item.right_dir_y      = rres.dir_y;
    out_item.right_excess     = rres.excess;
    out_item.right_level      = rres.level;
    out_item.left_pull_level  = ltrig_r[LAT-1];
    out_item.right_pull_level = rtrig_r[LAT-1];
  end

endmodule
